/* src/triangle_circumcenter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for triangle_circumcenter
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`define TRIANGLE_CIRCUMCENTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tcc assertion failed");
`define TCC_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("tcc implication failed");
`else
`define TCC_ASSERT(lbl, clk, rst_n, prop)
`define TCC_IMPLIES(lbl, clk, rst_n, a, b)
`endif
`endif

/* src/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants and types of the circumcenter pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;
	localparam int COORD_W_DEF = 16;
	localparam int QUOT_W      = 32;
	localparam int LIMIT_W     = 21;
	localparam int LIMIT_RESET = 1;

	typedef logic [LIMIT_W-1:0] limit_t;

	typedef struct packed {
		logic deg;
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
	} tcc_meta_t;
endpackage

/* src/tcc_geom.sv */
// ----------------------------------------------------------------------------
// tcc_geom
// Seven-stage front end: determinant, norms, weighted sums, magnitudes,
// degenerate test and quotient overflow test.
// ----------------------------------------------------------------------------
module tcc_geom #(
	parameter int W = tcc_pkg::COORD_W_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic signed [W-1:0]                      ax,
	input  logic signed [W-1:0]                      ay,
	input  logic signed [W-1:0]                      bx,
	input  logic signed [W-1:0]                      by,
	input  logic signed [W-1:0]                      cx,
	input  logic signed [W-1:0]                      cy,
	input  tcc_pkg::limit_t                          limit,
	output logic                                     out_valid,
	output logic [2*W+4+tcc_pkg::QUOT_W:0]           num_x,
	output logic [2*W+4+tcc_pkg::QUOT_W:0]           num_y,
	output logic [2*W+3:0]                           den,
	output tcc_pkg::tcc_meta_t                       meta
);
	import tcc_pkg::*;

	localparam int DIFF_W = W + 1;
	localparam int PD_W   = 2 * W + 1;
	localparam int SQ_W   = 2 * W;
	localparam int DS_W   = 2 * W + 3;
	localparam int D_W    = 2 * W + 4;
	localparam int NRM_W  = 2 * W + 1;
	localparam int NP_W   = 3 * W + 2;
	localparam int NUM_W  = 3 * W + 4;
	localparam int RW     = D_W + QUOT_W + 1;
	localparam int LW     = (D_W > LIMIT_W) ? D_W : LIMIT_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [W-1:0]      ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [DIFF_W-1:0] byc_s1, cya_s1, ayb_s1, cxb_s1, axc_s1, bxa_s1;
	logic signed [DIFF_W-1:0] byc_s2, cya_s2, ayb_s2, cxb_s2, axc_s2, bxa_s2;
	logic signed [DIFF_W-1:0] byc_s3, cya_s3, ayb_s3, cxb_s3, axc_s3, bxa_s3;
	logic signed [PD_W-1:0]   pd0_s2, pd1_s2, pd2_s2;
	logic signed [SQ_W-1:0]   sax_s2, say_s2, sbx_s2, sby_s2, scx_s2, scy_s2;
	logic signed [DS_W-1:0]   dsum_s3;
	logic signed [NRM_W-1:0]  na_s3, nb_s3, nc_s3;
	logic signed [D_W-1:0]    d_s4, d_s5;
	logic signed [NP_W-1:0]   px0_s4, px1_s4, px2_s4, py0_s4, py1_s4, py2_s4;
	logic signed [NUM_W-1:0]  nx_s5, ny_s5;
	logic [NUM_W-1:0]         mx_s6, my_s6;
	logic [D_W-1:0]           dm_s6, dm_s7;
	logic                     deg_s6, negx_s6, negy_s6;
	logic [RW-1:0]            rx_s7, ry_s7;
	tcc_meta_t                meta_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax;
			ay_s1  <= ay;
			bx_s1  <= bx;
			by_s1  <= by;
			cx_s1  <= cx;
			cy_s1  <= cy;
			byc_s1 <= DIFF_W'(by) - DIFF_W'(cy);
			cya_s1 <= DIFF_W'(cy) - DIFF_W'(ay);
			ayb_s1 <= DIFF_W'(ay) - DIFF_W'(by);
			cxb_s1 <= DIFF_W'(cx) - DIFF_W'(bx);
			axc_s1 <= DIFF_W'(ax) - DIFF_W'(cx);
			bxa_s1 <= DIFF_W'(bx) - DIFF_W'(ax);

			pd0_s2 <= PD_W'(ax_s1) * PD_W'(byc_s1);
			pd1_s2 <= PD_W'(bx_s1) * PD_W'(cya_s1);
			pd2_s2 <= PD_W'(cx_s1) * PD_W'(ayb_s1);
			sax_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			say_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sbx_s2 <= SQ_W'(bx_s1) * SQ_W'(bx_s1);
			sby_s2 <= SQ_W'(by_s1) * SQ_W'(by_s1);
			scx_s2 <= SQ_W'(cx_s1) * SQ_W'(cx_s1);
			scy_s2 <= SQ_W'(cy_s1) * SQ_W'(cy_s1);
			byc_s2 <= byc_s1;
			cya_s2 <= cya_s1;
			ayb_s2 <= ayb_s1;
			cxb_s2 <= cxb_s1;
			axc_s2 <= axc_s1;
			bxa_s2 <= bxa_s1;

			dsum_s3 <= DS_W'(pd0_s2) + DS_W'(pd1_s2) + DS_W'(pd2_s2);
			na_s3   <= NRM_W'(sax_s2) + NRM_W'(say_s2);
			nb_s3   <= NRM_W'(sbx_s2) + NRM_W'(sby_s2);
			nc_s3   <= NRM_W'(scx_s2) + NRM_W'(scy_s2);
			byc_s3  <= byc_s2;
			cya_s3  <= cya_s2;
			ayb_s3  <= ayb_s2;
			cxb_s3  <= cxb_s2;
			axc_s3  <= axc_s2;
			bxa_s3  <= bxa_s2;

			d_s4   <= D_W'(dsum_s3) <<< 1;
			px0_s4 <= NP_W'(na_s3) * NP_W'(byc_s3);
			px1_s4 <= NP_W'(nb_s3) * NP_W'(cya_s3);
			px2_s4 <= NP_W'(nc_s3) * NP_W'(ayb_s3);
			py0_s4 <= NP_W'(na_s3) * NP_W'(cxb_s3);
			py1_s4 <= NP_W'(nb_s3) * NP_W'(axc_s3);
			py2_s4 <= NP_W'(nc_s3) * NP_W'(bxa_s3);

			d_s5  <= d_s4;
			nx_s5 <= NUM_W'(px0_s4) + NUM_W'(px1_s4) + NUM_W'(px2_s4);
			ny_s5 <= NUM_W'(py0_s4) + NUM_W'(py1_s4) + NUM_W'(py2_s4);

			mx_s6   <= nx_s5[NUM_W-1] ? NUM_W'(-nx_s5) : NUM_W'(nx_s5);
			my_s6   <= ny_s5[NUM_W-1] ? NUM_W'(-ny_s5) : NUM_W'(ny_s5);
			dm_s6   <= d_s5[D_W-1] ? D_W'(-d_s5) : D_W'(d_s5);
			negx_s6 <= nx_s5[NUM_W-1] ^ d_s5[D_W-1];
			negy_s6 <= ny_s5[NUM_W-1] ^ d_s5[D_W-1];
			deg_s6  <= (d_s5 == '0) ||
				(LW'(d_s5[D_W-1] ? D_W'(-d_s5) : D_W'(d_s5)) < LW'(limit));

			rx_s7         <= RW'(mx_s6);
			ry_s7         <= RW'(my_s6);
			dm_s7         <= dm_s6;
			meta_s7.deg   <= deg_s6;
			meta_s7.neg_x <= negx_s6;
			meta_s7.neg_y <= negy_s6;
			meta_s7.ovf_x <= RW'(mx_s6) >= (RW'(dm_s6) << QUOT_W);
			meta_s7.ovf_y <= RW'(my_s6) >= (RW'(dm_s6) << QUOT_W);
		end
	end

	assign out_valid = v_s7;
	assign num_x     = rx_s7;
	assign num_y     = ry_s7;
	assign den       = dm_s7;
	assign meta      = meta_s7;
endmodule

/* src/tcc_div_step.sv */
// ----------------------------------------------------------------------------
// tcc_div_step
// One registered restoring-division step for both center coordinates.
// ----------------------------------------------------------------------------
module tcc_div_step #(
	parameter int RW    = 69,
	parameter int D_W   = 36,
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [RW-1:0]                 in_rx,
	input  logic [RW-1:0]                 in_ry,
	input  logic [tcc_pkg::QUOT_W-1:0]    in_qx,
	input  logic [tcc_pkg::QUOT_W-1:0]    in_qy,
	input  logic [D_W-1:0]                in_den,
	input  tcc_pkg::tcc_meta_t            in_meta,
	output logic                          out_valid,
	output logic [RW-1:0]                 out_rx,
	output logic [RW-1:0]                 out_ry,
	output logic [tcc_pkg::QUOT_W-1:0]    out_qx,
	output logic [tcc_pkg::QUOT_W-1:0]    out_qy,
	output logic [D_W-1:0]                out_den,
	output tcc_pkg::tcc_meta_t            out_meta
);
	import tcc_pkg::*;

	logic [RW:0] dx, dy, sd;

	always_comb begin
		sd = (RW+1)'(in_den) << SHIFT;
		dx = {1'b0, in_rx} - sd;
		dy = {1'b0, in_ry} - sd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rx   <= dx[RW] ? in_rx : dx[RW-1:0];
			out_ry   <= dy[RW] ? in_ry : dy[RW-1:0];
			out_qx   <= in_qx | (dx[RW] ? '0 : (QUOT_W'(1) << SHIFT));
			out_qy   <= in_qy | (dy[RW] ? '0 : (QUOT_W'(1) << SHIFT));
			out_den  <= in_den;
			out_meta <= in_meta;
		end
	end
endmodule

/* src/triangle_circumcenter.sv */
// ----------------------------------------------------------------------------
// triangle_circumcenter
// Pipeline: 7 front-end stages, 32 division steps, output register.
// Throughput: one beat per cycle while m_tready does not stall the output; the divider steps are fully pipelined.
// A stall on the master side freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits and loads degenerate_limit with 1.
// ----------------------------------------------------------------------------
`include "triangle_circumcenter_assert.svh"
module triangle_circumcenter #(
	parameter int COORD_WIDTH = tcc_pkg::COORD_W_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  tcc_pkg::limit_t                       cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// center_x, center_y
	output logic [2*tcc_pkg::QUOT_W-1:0]          m_tdata,
	// degenerate, saturated
	output logic [1:0]                            m_tuser
);
	import tcc_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int D_W = 2 * W + 4;
	localparam int RW  = D_W + QUOT_W + 1;
	localparam logic [QUOT_W-1:0] MAX_POS = {1'b0, {(QUOT_W-1){1'b1}}};
	localparam logic [QUOT_W-1:0] MIN_NEG = {1'b1, {(QUOT_W-1){1'b0}}};

	limit_t limit_q;
	logic   adv;

	logic              v_p   [QUOT_W+1];
	logic [RW-1:0]     rx_p  [QUOT_W+1];
	logic [RW-1:0]     ry_p  [QUOT_W+1];
	logic [QUOT_W-1:0] qx_p  [QUOT_W+1];
	logic [QUOT_W-1:0] qy_p  [QUOT_W+1];
	logic [D_W-1:0]    den_p [QUOT_W+1];
	tcc_meta_t         meta_p[QUOT_W+1];

	logic [QUOT_W-1:0] cx_q, cy_q, cx_n, cy_n;
	logic              deg_q, sat_q, sat_n, sx, sy;
	logic              valid_q;
	tcc_meta_t         mf;
	logic [QUOT_W-1:0] qxf, qyf;

	assign adv      = !valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= limit_t'(LIMIT_RESET);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	tcc_geom #(.W(W)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.ax        (s_tdata[0*W +: W]),
		.ay        (s_tdata[1*W +: W]),
		.bx        (s_tdata[2*W +: W]),
		.by        (s_tdata[3*W +: W]),
		.cx        (s_tdata[4*W +: W]),
		.cy        (s_tdata[5*W +: W]),
		.limit     (limit_q),
		.out_valid (v_p[0]),
		.num_x     (rx_p[0]),
		.num_y     (ry_p[0]),
		.den       (den_p[0]),
		.meta      (meta_p[0])
	);

	assign qx_p[0] = '0;
	assign qy_p[0] = '0;

	for (genvar i = 0; i < QUOT_W; i++) begin : g_div
		tcc_div_step #(.RW(RW), .D_W(D_W), .SHIFT(QUOT_W-1-i)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (v_p[i]),
			.in_rx     (rx_p[i]),
			.in_ry     (ry_p[i]),
			.in_qx     (qx_p[i]),
			.in_qy     (qy_p[i]),
			.in_den    (den_p[i]),
			.in_meta   (meta_p[i]),
			.out_valid (v_p[i+1]),
			.out_rx    (rx_p[i+1]),
			.out_ry    (ry_p[i+1]),
			.out_qx    (qx_p[i+1]),
			.out_qy    (qy_p[i+1]),
			.out_den   (den_p[i+1]),
			.out_meta  (meta_p[i+1])
		);
	end

	always_comb begin
		mf  = meta_p[QUOT_W];
		qxf = qx_p[QUOT_W];
		qyf = qy_p[QUOT_W];
		if (mf.neg_x) begin
			sx   = mf.ovf_x || (qxf > MIN_NEG);
			cx_n = sx ? MIN_NEG : QUOT_W'(-qxf);
		end else begin
			sx   = mf.ovf_x || qxf[QUOT_W-1];
			cx_n = sx ? MAX_POS : qxf;
		end
		if (mf.neg_y) begin
			sy   = mf.ovf_y || (qyf > MIN_NEG);
			cy_n = sy ? MIN_NEG : QUOT_W'(-qyf);
		end else begin
			sy   = mf.ovf_y || qyf[QUOT_W-1];
			cy_n = sy ? MAX_POS : qyf;
		end
		sat_n = sx || sy;
		if (mf.deg) begin
			cx_n  = '0;
			cy_n  = '0;
			sat_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= v_p[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q  <= cx_n;
			cy_q  <= cy_n;
			deg_q <= mf.deg;
			sat_q <= sat_n;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {cy_q, cx_q};
	assign m_tuser  = {sat_q, deg_q};

	`TCC_IMPLIES(a_deg_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tuser[1])
	`TCC_IMPLIES(a_sat_extreme, clk, arst_n, m_tvalid && m_tuser[1], cx_q == MAX_POS || cx_q == MIN_NEG || cy_q == MAX_POS || cy_q == MIN_NEG)
	`TCC_ASSERT(a_cfg_write, clk, arst_n, cfg_we |=> limit_q == $past(cfg_wdata))
endmodule
